// ----- rtl/core/dbr_pkg.sv -----
package dbr_pkg;

   localparam int DEF_BOARD_ROWS = 9;
   localparam int DEF_BOARD_COLS = 17;

   localparam int REQ_W      = 2;
   localparam int DATA_W     = 8;
   localparam int CELL_ROW_W = 4;
   localparam int CELL_COL_W = 5;
   localparam int SYMBOL_W   = 7;
   localparam int COUNT_W    = 4;

   localparam logic [COUNT_W-1:0]  COUNT_MAX  = 4'd14;
   localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [SYMBOL_W-1:0] CHAR_START = 7'h53;
   localparam logic [SYMBOL_W-1:0] CHAR_END   = 7'h45;

   typedef enum logic [REQ_W-1:0] {
      REQ_FEED  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic step_first;
      logic step_next;
      logic rd_en;
      logic rsp_load;
   } dbr_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dbr_sts_type;

   function automatic logic [SYMBOL_W-1:0] art_char(input logic [COUNT_W-1:0] cnt);
      logic [SYMBOL_W-1:0] ch;
      case (cnt)
         4'd0:    ch = 7'h20;
         4'd1:    ch = 7'h2E;
         4'd2:    ch = 7'h6F;
         4'd3:    ch = 7'h2B;
         4'd4:    ch = 7'h3D;
         4'd5:    ch = 7'h2A;
         4'd6:    ch = 7'h42;
         4'd7:    ch = 7'h4F;
         4'd8:    ch = 7'h58;
         4'd9:    ch = 7'h40;
         4'd10:   ch = 7'h25;
         4'd11:   ch = 7'h26;
         4'd12:   ch = 7'h23;
         4'd13:   ch = 7'h2F;
         4'd14:   ch = 7'h5E;
         default: ch = 7'h20;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/core/dbr_if.sv -----
interface dbr_req_if import dbr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_W-1:0]      req_type;
   logic [DATA_W-1:0]     data_byte;
   logic [CELL_ROW_W-1:0] cell_row;
   logic [CELL_COL_W-1:0] cell_col;

   modport source (output valid, req_type, data_byte, cell_row, cell_col, input ready);
   modport sink   (input valid, req_type, data_byte, cell_row, cell_col, output ready);
endinterface

interface dbr_rsp_if import dbr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic [COUNT_W-1:0]  visit_count;

   modport source (output valid, symbol, visit_count, input ready);
   modport sink   (input valid, symbol, visit_count, output ready);
endinterface

// ----- rtl/core/dbr_ctrl.sv -----
module dbr_ctrl import dbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [REQ_W-1:0] req_type,
   input  logic             rsp_ready,
   input  dbr_sts_type      sts,
   output logic             req_ready,
   output logic             rsp_valid,
   output dbr_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOVE,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] move_cnt_ff, move_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      move_cnt_in = move_cnt_ff;
      cmd         = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_code_type'(req_type))
                  REQ_FEED: begin
                     cmd.step_first = 1'b1;
                     move_cnt_in    = 2'd0;
                     state_in       = ST_MOVE;
                  end
                  REQ_READ: begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_READ;
                  end
                  REQ_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            cmd.step_next = 1'b1;
            move_cnt_in   = move_cnt_ff + 2'd1;
            if (move_cnt_ff == 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ, ST_HOLD: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         move_cnt_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         move_cnt_ff  <= move_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_feed_four_moves: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_FEED) |=>
         state_ff == ST_MOVE ##1 state_ff == ST_MOVE ##1 state_ff == ST_MOVE
         ##1 state_ff == ST_IDLE)
      else $error("feed did not take three follow-up moves");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_READ && !rsp_valid_ff) |=> ##1 rsp_valid_ff)
      else $error("read result not presented two cycles after accept");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_CLEAR) |=> !req_ready ##1 !req_ready)
      else $error("item accepted during clearing sweep");

endmodule

// ----- rtl/core/dbr_datapath.sv -----
module dbr_datapath import dbr_pkg::*; #(
   parameter int BOARD_ROWS = DEF_BOARD_ROWS,
   parameter int BOARD_COLS = DEF_BOARD_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dbr_cmd_type           cmd,
   input  logic [DATA_W-1:0]     data_byte,
   input  logic [CELL_ROW_W-1:0] cell_row,
   input  logic [CELL_COL_W-1:0] cell_col,
   output dbr_sts_type           sts,
   output logic [SYMBOL_W-1:0]   symbol,
   output logic [COUNT_W-1:0]    visit_count
);

   localparam int DEPTH     = BOARD_ROWS * BOARD_COLS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_W     = $clog2(BOARD_ROWS);
   localparam int COL_W     = $clog2(BOARD_COLS);
   localparam int START_ROW = BOARD_ROWS / 2;
   localparam int START_COL = BOARD_COLS / 2;

   logic [COUNT_W-1:0] mem [DEPTH];

   logic [ROW_W-1:0]    pos_row_ff, pos_row_in;
   logic [COL_W-1:0]    pos_col_ff, pos_col_in;
   logic [DATA_W-3:0]   byte_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic                wb_valid_ff;
   logic [ADDR_W-1:0]   wb_addr_ff;
   logic [COUNT_W-1:0]  rd_data_ff;
   logic                fwd_ff;
   logic [COUNT_W-1:0]  fwd_data_ff;
   logic                oor_ff, start_ff, at_pos_ff;
   logic [SYMBOL_W-1:0] symbol_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic                step;
   logic [1:0]          pair;
   logic [ADDR_W-1:0]   step_addr;
   logic [ADDR_W-1:0]   cell_addr;
   logic                oor;
   logic                re, we;
   logic [ADDR_W-1:0]   ra, wa;
   logic [COUNT_W-1:0]  wd;
   logic [COUNT_W-1:0]  eff;
   logic [SYMBOL_W-1:0] sym_sel;

   assign step = cmd.step_first || cmd.step_next;
   assign pair = cmd.step_first ? data_byte[1:0] : byte_ff[1:0];

   always_comb begin
      pos_col_in = pos_col_ff;
      pos_row_in = pos_row_ff;
      if (pair[0]) begin
         if (pos_col_ff != COL_W'(BOARD_COLS - 1)) begin
            pos_col_in = pos_col_ff + COL_W'(1);
         end
      end else begin
         if (pos_col_ff != '0) begin
            pos_col_in = pos_col_ff - COL_W'(1);
         end
      end
      if (pair[1]) begin
         if (pos_row_ff != ROW_W'(BOARD_ROWS - 1)) begin
            pos_row_in = pos_row_ff + ROW_W'(1);
         end
      end else begin
         if (pos_row_ff != '0) begin
            pos_row_in = pos_row_ff - ROW_W'(1);
         end
      end
   end

   assign step_addr = ADDR_W'(pos_row_in) * ADDR_W'(BOARD_COLS) + ADDR_W'(pos_col_in);

   assign oor = ({1'b0, cell_row} >= (CELL_ROW_W + 1)'(BOARD_ROWS)) ||
                ({1'b0, cell_col} >= (CELL_COL_W + 1)'(BOARD_COLS));
   assign cell_addr = oor ? '0 :
      ADDR_W'(cell_row[ROW_W-1:0]) * ADDR_W'(BOARD_COLS) + ADDR_W'(cell_col[COL_W-1:0]);

   assign eff = fwd_ff ? fwd_data_ff : rd_data_ff;

   assign re = step || cmd.rd_en;
   assign ra = cmd.rd_en ? cell_addr : step_addr;
   assign we = cmd.clear_step || wb_valid_ff;
   assign wa = cmd.clear_step ? clr_addr_ff : wb_addr_ff;
   assign wd = cmd.clear_step ? '0 : ((eff >= COUNT_MAX) ? '0 : eff + COUNT_W'(1));

   assign sts.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_data_ff  <= mem[ra];
         fwd_data_ff <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff  <= ROW_W'(START_ROW);
         pos_col_ff  <= COL_W'(START_COL);
         clr_addr_ff <= '0;
         wb_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         wb_valid_ff <= step;
         if (cmd.clear_start) begin
            pos_row_ff  <= ROW_W'(START_ROW);
            pos_col_ff  <= COL_W'(START_COL);
            clr_addr_ff <= '0;
         end else if (step) begin
            pos_row_ff <= pos_row_in;
            pos_col_ff <= pos_col_in;
         end
         if (cmd.clear_step && !sts.clear_last) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (re) begin
            fwd_ff <= we && (wa == ra);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_first) begin
         byte_ff <= data_byte[DATA_W-1:2];
      end else if (cmd.step_next) begin
         byte_ff <= {2'b00, byte_ff[DATA_W-3:2]};
      end
      if (step) begin
         wb_addr_ff <= step_addr;
      end
      if (cmd.rd_en) begin
         oor_ff    <= oor;
         start_ff  <= (cell_row == CELL_ROW_W'(START_ROW)) &&
                      (cell_col == CELL_COL_W'(START_COL));
         at_pos_ff <= (cell_row == CELL_ROW_W'(pos_row_ff)) &&
                      (cell_col == CELL_COL_W'(pos_col_ff));
      end
      if (cmd.rsp_load) begin
         symbol_ff <= sym_sel;
         count_ff  <= oor_ff ? '0 : eff;
      end
   end

   always_comb begin
      if (oor_ff) begin
         sym_sel = CHAR_SPACE;
      end else if (start_ff) begin
         sym_sel = CHAR_START;
      end else if (at_pos_ff) begin
         sym_sel = CHAR_END;
      end else begin
         sym_sel = art_char(eff);
      end
   end

   assign symbol      = symbol_ff;
   assign visit_count = count_ff;

   a_pos_on_board: assert property (@(posedge clock) disable iff (reset)
      (int'(pos_row_ff) < BOARD_ROWS) && (int'(pos_col_ff) < BOARD_COLS))
      else $error("bishop left the board");

   a_restart_center: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_start |=> (pos_row_ff == ROW_W'(START_ROW)) &&
                          (pos_col_ff == COL_W'(START_COL)) && (clr_addr_ff == '0))
      else $error("restart did not recenter the bishop");

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (int'(wb_addr_ff) < DEPTH) && !cmd.clear_step)
      else $error("count write-back out of range or during clearing");

endmodule

// ----- rtl/core/drunken_bishop_randomart.sv -----
// Drunken-bishop random art engine on a BOARD_ROWS x BOARD_COLS board.
// Request channel (req_ch): req_type selects feed (walk four moves from the
// bits of data_byte, low pair first), read (return one cell) or restart
// (recenter the bishop and zero every visit count). Undefined codes are
// taken and dropped.
// Response channel (rsp_ch): one item per read, with the cell's symbol
// ('S' start, 'E' current position, else the art character) and its visit
// count modulo 15. Reads outside the board return a space and zero.
// Timing: a feed makes one move per cycle through the single counter
// memory (read, increment, write back with forwarding). A read registers
// the cell's count, then loads its item into the output register once
// that is free. A restart recenters, then sweeps all BOARD_ROWS*BOARD_COLS
// entries (153 by default), one per cycle; req_ch.ready stays low during
// the sweep. Reset runs the same sweep before the first request is taken.
// The response is held in an output register; while rsp_ch.ready is low,
// feeds and restarts are still accepted, and a further read is taken but
// then holds req_ch.ready low until the held item is taken.
module drunken_bishop_randomart import dbr_pkg::*; #(
   parameter int BOARD_ROWS = DEF_BOARD_ROWS,
   parameter int BOARD_COLS = DEF_BOARD_COLS
) (
   input logic       clock,
   input logic       reset,
   dbr_req_if.sink   req_ch,
   dbr_rsp_if.source rsp_ch
);

   dbr_cmd_type cmd;
   dbr_sts_type sts;

   dbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   dbr_datapath #(
      .BOARD_ROWS (BOARD_ROWS),
      .BOARD_COLS (BOARD_COLS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_ch.data_byte),
      .cell_row    (req_ch.cell_row),
      .cell_col    (req_ch.cell_col),
      .sts         (sts),
      .symbol      (rsp_ch.symbol),
      .visit_count (rsp_ch.visit_count)
   );

endmodule

// ----- bench/drunken_bishop_randomart_check.sv -----
module drunken_bishop_randomart_check import dbr_pkg::*; (
   input  logic clock,
   input  logic reset,
   dbr_req_if   req_mon,
   dbr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS     = DEF_BOARD_ROWS;
   localparam int COLS     = DEF_BOARD_COLS;
   localparam int CELLS    = ROWS * COLS;
   localparam int HOME_ROW = ROWS / 2;
   localparam int HOME_COL = COLS / 2;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [COUNT_W-1:0]  visit_count;
   } cell_view_type;

   logic [COUNT_W-1:0] visits [CELLS];
   int                 bishop_row;
   int                 bishop_col;
   cell_view_type      awaited_views [$];
   string              art_glyphs = " .o+=*BOX@%&#/^";
   int                 mismatches = 0;
   int                 outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   task automatic recenter();
      foreach (visits[i]) visits[i] = '0;
      bishop_row = HOME_ROW;
      bishop_col = HOME_COL;
   endtask

   task automatic walk(input logic [DATA_W-1:0] steps);
      int idx;
      for (int k = 0; k < 4; k++) begin
         if (steps[2*k]) begin
            if (bishop_col < COLS - 1) bishop_col++;
         end else if (bishop_col > 0) begin
            bishop_col--;
         end
         if (steps[2*k+1]) begin
            if (bishop_row < ROWS - 1) bishop_row++;
         end else if (bishop_row > 0) begin
            bishop_row--;
         end
         idx = bishop_row * COLS + bishop_col;
         visits[idx] = (visits[idx] == COUNT_MAX) ? '0 : visits[idx] + 1'b1;
      end
   endtask

   function automatic cell_view_type view_of(input logic [CELL_ROW_W-1:0] row,
                                             input logic [CELL_COL_W-1:0] col);
      cell_view_type v;
      byte           ch;
      if (row >= ROWS || col >= COLS) begin
         v.symbol      = CHAR_SPACE;
         v.visit_count = '0;
      end else begin
         v.visit_count = visits[row * COLS + col];
         if (row == HOME_ROW && col == HOME_COL) begin
            v.symbol = CHAR_START;
         end else if (row == bishop_row && col == bishop_col) begin
            v.symbol = CHAR_END;
         end else begin
            ch       = art_glyphs[v.visit_count];
            v.symbol = ch[SYMBOL_W-1:0];
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin
      cell_view_type want;
      if (reset) begin
         recenter();
         awaited_views.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_views.size() == 0) begin
               $error("unexpected item: symbol %0h visit_count %0d",
                      rsp_mon.symbol, rsp_mon.visit_count);
               mismatches++;
            end else begin
               want = awaited_views.pop_front();
               if (rsp_mon.symbol !== want.symbol) begin
                  $error("symbol: expected %0h, got %0h", want.symbol, rsp_mon.symbol);
                  mismatches++;
               end
               if (rsp_mon.visit_count !== want.visit_count) begin
                  $error("visit_count: expected %0d, got %0d",
                         want.visit_count, rsp_mon.visit_count);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_FEED:  walk(req_mon.data_byte);
               REQ_READ:  awaited_views.push_back(view_of(req_mon.cell_row, req_mon.cell_col));
               REQ_CLEAR: recenter();
               default:   ;
            endcase
         end
      end
      outstanding <= awaited_views.size();
   end

endmodule

// ----- bench/drunken_bishop_randomart_test.sv -----
module drunken_bishop_randomart_test import dbr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int ROWS         = DEF_BOARD_ROWS;
   localparam int COLS         = DEF_BOARD_COLS;
   localparam int RANDOM_ITEMS = 750;
   localparam int HOLD_CYCLES  = 80;

   logic clock    = 1'b0;
   logic reset;
   logic hold_rsp = 1'b0;
   logic idling   = 1'b1;
   int   fail_count;
   int   pending;

   dbr_req_if req_ch ();
   dbr_rsp_if rsp_ch ();

   drunken_bishop_randomart dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   drunken_bishop_randomart_check board_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic offer(input logic [REQ_W-1:0]      code,
                        input logic [DATA_W-1:0]     byte_in,
                        input logic [CELL_ROW_W-1:0] row,
                        input logic [CELL_COL_W-1:0] col);
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= code;
      req_ch.data_byte <= byte_in;
      req_ch.cell_row  <= row;
      req_ch.cell_col  <= col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic feed(input logic [DATA_W-1:0] steps);
      offer(REQ_FEED, steps, 4'($urandom), 5'($urandom));
   endtask

   task automatic read(input logic [CELL_ROW_W-1:0] row, input logic [CELL_COL_W-1:0] col);
      offer(REQ_READ, 8'($urandom), row, col);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         feed(8'($urandom));
      else if (pick < 80)
         read(4'($urandom_range(0, ROWS - 1)), 5'($urandom_range(0, COLS - 1)));
      else if (pick < 92)
         read(4'($urandom), 5'($urandom));
      else if (pick < 94)
         offer(REQ_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom));
      else
         offer(REQ_UNUSED, 8'($urandom), 4'($urandom), 5'($urandom));
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= REQ_FEED;
      req_ch.data_byte <= '0;
      req_ch.cell_row  <= '0;
      req_ch.cell_col  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk into the top-left corner and wrap its count
      read(4'd4, 5'd8);
      feed(8'h00);
      feed(8'h00);
      feed(8'h00);
      feed(8'h00);
      feed(8'h00);
      feed(8'hFC);
      read(4'd0, 5'd0);
      read(4'd0, 5'd4);
      read(4'd3, 5'd3);
      feed(8'h00);
      read(4'd0, 5'd0);
      // slide to the opposite corner and along its edges
      feed(8'hFF);
      feed(8'hFF);
      feed(8'hFF);
      feed(8'hFF);
      feed(8'h55);
      feed(8'hAA);
      read(4'd8, 5'd12);
      read(4'd9, 5'd16);
      read(4'd2, 5'd31);
      offer(REQ_UNUSED, 8'hFF, 4'hF, 5'h1F);
      offer(REQ_CLEAR, 8'h00, 4'h0, 5'h00);
      feed(8'h33);
      read(4'd4, 5'd8);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_rsp = 1'b1;
         if (n == 450) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (n == 600)
            idling = 1'b0;
         if (n >= 300 && n < 312)
            read(4'($urandom_range(0, ROWS - 1)), 5'($urandom_range(0, COLS - 1)));
         else
            random_item();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("drunken_bishop_randomart_test OK");
      else
         $display("drunken_bishop_randomart_test NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("drunken_bishop_randomart_test NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/dbr_pkg.sv
rtl/core/dbr_if.sv
rtl/core/dbr_ctrl.sv
rtl/core/dbr_datapath.sv
rtl/core/drunken_bishop_randomart.sv
bench/drunken_bishop_randomart_check.sv
bench/drunken_bishop_randomart_test.sv
